// File: rtl/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

	// Fixed field widths of the item and result words.
	localparam int VERTEX_W = 6;
	localparam int COUNT_W  = 7;

	// Default size of the label chain and the vertex count after reset.
	localparam int         MAX_VERTICES_DEF = 64;
	localparam logic [6:0] VERTEX_COUNT_RST = 7'd64;

	// Item kinds.
	localparam logic KIND_CLEAR = 1'b0;
	localparam logic KIND_EDGE  = 1'b1;

	// Control part of the token that walks down the label chain. A lookup
	// token collects the labels of both endpoints. A relabel token rewrites
	// every label that equals its "from" label.
	typedef struct packed {
		logic                vld;
		logic                relabel;
		logic [VERTEX_W-1:0] a;
		logic [VERTEX_W-1:0] b;
	} token_ctl_t;

endpackage

`default_nettype wire

// File: rtl/sfr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfr_item_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [sfr_pkg::VERTEX_W-1:0]  first_vertex;
	logic [sfr_pkg::VERTEX_W-1:0]  second_vertex;

	modport source (output valid, output kind, output first_vertex, output second_vertex,
		input ready);
	modport sink (input valid, input kind, input first_vertex, input second_vertex,
		output ready);
endinterface

interface sfr_result_if;
	logic                         valid;
	logic                         ready;
	logic                         edge_added;
	logic                         bad_vertex;
	logic [sfr_pkg::COUNT_W-1:0]  components;
	logic                         connected;

	modport source (output valid, output edge_added, output bad_vertex, output components,
		output connected, input ready);
	modport sink (input valid, input edge_added, input bad_vertex, input components,
		input connected, output ready);
endinterface

interface sfr_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [sfr_pkg::COUNT_W-1:0]  vertex_count;

	modport source (output valid, output vertex_count, input ready);
	modport sink (input valid, input vertex_count, output ready);
endinterface

`default_nettype wire

// File: rtl/spanning_forest_by_relabel_core.sv
// Spanning-forest builder for an unweighted graph, one component label per vertex.
// Channels: "item" takes words of kind, first_vertex, second_vertex; "result"
// gives one word per item (edge_added, bad_vertex, components, connected);
// "cfg" writes vertex_count, which also clears the forest. All use valid/ready.
// A clear word resets every label; it and a word with an endpoint at or beyond
// the vertex count in use go straight from idle to the done state and then to
// the output register. Any other edge sends a lookup token down the chain of
// MAX_VERTICES label cells; when the labels already match, the word goes to the
// done state once the token leaves the chain. If they differ, a relabel token
// follows over the same chain and the edge is joined when it leaves; the token
// moves one cell per cycle. Item.ready rises again as the result word enters
// the output register and the sequencer returns to idle.
// One word is worked on at a time; item.ready is high only when the block is
// idle. The finished word sits in an output register, so the next item word is
// taken while a result still waits. When the receiver stalls, a second result
// waits inside the block and no further item word is taken until it drains.
// Reset sets vertex_count to 64, every label to its own index and the count to
// 64, clamped to MAX_VERTICES; no clearing pass is needed, the cells reset at once.
`timescale 1ns / 1ps
`default_nettype none

module spanning_forest_by_relabel_core #(
	parameter int MAX_VERTICES = sfr_pkg::MAX_VERTICES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sfr_item_if.sink     item,
	sfr_result_if.source result,
	sfr_cfg_if.sink      cfg
);
	import sfr_pkg::*;

	localparam int LabelW = $clog2(MAX_VERTICES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_RELAB,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [COUNT_W-1:0]   vc_q;
	logic [COUNT_W-1:0]   total_q;
	logic                 res_added_q;
	logic                 res_bad_q;
	token_ctl_t           inj_ctl_q;
	logic [LabelW-1:0]    inj_from_q;
	logic [LabelW-1:0]    inj_to_q;
	logic                 out_vld_q;
	logic                 out_added_q;
	logic                 out_bad_q;
	logic [COUNT_W-1:0]   out_comp_q;
	logic                 out_conn_q;

	token_ctl_t           ctl_w  [MAX_VERTICES+1];
	logic [LabelW-1:0]    from_w [MAX_VERTICES+1];
	logic [LabelW-1:0]    to_w   [MAX_VERTICES+1];

	logic                 item_acc;
	logic                 cfg_acc;
	logic                 clr;
	logic [COUNT_W-1:0]   n_eff;
	logic                 bad;
	logic                 out_free;
	logic                 chain_exit;

	// Vertex count in use: zero acts as one, anything above the chain length
	// acts as the chain length.
	function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
		logic [COUNT_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = COUNT_W'(1);
		end else if (32'(v) > MAX_VERTICES) begin
			r = COUNT_W'(MAX_VERTICES);
		end
		return r;
	endfunction

	assign n_eff      = clamp_count(vc_q);
	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign item_acc   = item.valid && item.ready;
	assign cfg_acc    = cfg.valid && cfg.ready;
	assign clr        = cfg_acc || (item_acc && (item.kind == KIND_CLEAR));
	assign bad        = ({1'b0, item.first_vertex} >= n_eff) ||
	                    ({1'b0, item.second_vertex} >= n_eff);
	assign out_free   = !out_vld_q || result.ready;
	assign chain_exit = ctl_w[MAX_VERTICES].vld;

	// The label chain. Cell i holds the label of vertex i.
	assign ctl_w[0]  = inj_ctl_q;
	assign from_w[0] = inj_from_q;
	assign to_w[0]   = inj_to_q;

	for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
		sfr_cell #(
			.Idx    (i),
			.LabelW (LabelW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clr      (clr),
			.ctl_in   (ctl_w[i]),
			.from_in  (from_w[i]),
			.to_in    (to_w[i]),
			.ctl_out  (ctl_w[i+1]),
			.from_out (from_w[i+1]),
			.to_out   (to_w[i+1])
		);
	end

	// Sequencer: accepts a word, runs the lookup and relabel passes, and
	// hands the result to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vc_q        <= VERTEX_COUNT_RST;
			total_q     <= clamp_count(VERTEX_COUNT_RST);
			res_added_q <= 1'b0;
			res_bad_q   <= 1'b0;
			inj_ctl_q   <= '0;
			inj_from_q  <= '0;
			inj_to_q    <= '0;
			out_vld_q   <= 1'b0;
			out_added_q <= 1'b0;
			out_bad_q   <= 1'b0;
			out_comp_q  <= '0;
			out_conn_q  <= 1'b0;
		end else begin
			// The output register fills as a word finishes and empties when
			// the receiver takes it.
			if (state_q == S_DONE && out_free) begin
				out_vld_q   <= 1'b1;
				out_added_q <= res_added_q;
				out_bad_q   <= res_bad_q;
				out_comp_q  <= total_q;
				out_conn_q  <= (total_q == COUNT_W'(1));
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end

			if (cfg_acc) begin
				vc_q <= cfg.vertex_count;
			end

			// A register write or a clear word restarts the count; a joined
			// edge lowers it by one, never below one.
			if (cfg_acc) begin
				total_q <= clamp_count(cfg.vertex_count);
			end else if (item_acc && (item.kind == KIND_CLEAR)) begin
				total_q <= n_eff;
			end else if (state_q == S_RELAB && chain_exit && (total_q > COUNT_W'(1))) begin
				total_q <= total_q - COUNT_W'(1);
			end

			if (item_acc) begin
				res_added_q <= 1'b0;
				res_bad_q   <= (item.kind == KIND_EDGE) && bad;
			end else if (state_q == S_RELAB && chain_exit) begin
				res_added_q <= 1'b1;
			end

			// Token injection. The lookup token comes with an accepted edge;
			// the relabel token follows when the two labels differ. The token
			// now carries label[b] as "from" and label[a] as "to".
			if (item_acc && (item.kind == KIND_EDGE) && !bad) begin
				inj_ctl_q <= '{vld: 1'b1, relabel: 1'b0,
					a: item.first_vertex, b: item.second_vertex};
			end else if (state_q == S_LOOK && chain_exit &&
					(from_w[MAX_VERTICES] != to_w[MAX_VERTICES])) begin
				inj_ctl_q <= '{vld: 1'b1, relabel: 1'b1,
					a: ctl_w[MAX_VERTICES].a, b: ctl_w[MAX_VERTICES].b};
			end else begin
				inj_ctl_q.vld <= 1'b0;
			end

			if (state_q == S_LOOK && chain_exit) begin
				inj_from_q <= from_w[MAX_VERTICES];
				inj_to_q   <= to_w[MAX_VERTICES];
			end

			unique case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						if (item.kind == KIND_CLEAR || bad) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					if (chain_exit) begin
						if (from_w[MAX_VERTICES] != to_w[MAX_VERTICES]) begin
							state_q <= S_RELAB;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_RELAB: begin
					if (chain_exit) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid      = out_vld_q;
	assign result.edge_added = out_added_q;
	assign result.bad_vertex = out_bad_q;
	assign result.components = out_comp_q;
	assign result.connected  = out_conn_q;

	// A joined edge is never also a bad-endpoint edge.
	a_added_not_bad: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.edge_added && result.bad_vertex))
		else $error("edge reported both added and bad");

	// The connected flag matches the reported count.
	a_conn_match: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.connected == (result.components == COUNT_W'(1))))
		else $error("connected flag disagrees with component count");

	// No token leaves the chain while the block is idle.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !chain_exit)
		else $error("token left the label chain while idle");

	// The component count only grows through a clear.
	a_count_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		!clr |=> (total_q <= $past(total_q)))
		else $error("component count grew without a clear");

endmodule

`default_nettype wire

// File: rtl/sfr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One vertex of the label chain: holds the vertex's component label and
// passes the token on to the next cell through a register.
module sfr_cell #(
	parameter int Idx    = 0,
	parameter int LabelW = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  sfr_pkg::token_ctl_t ctl_in,
	input  logic [LabelW-1:0]   from_in,
	input  logic [LabelW-1:0]   to_in,
	output sfr_pkg::token_ctl_t ctl_out,
	output logic [LabelW-1:0]   from_out,
	output logic [LabelW-1:0]   to_out
);
	import sfr_pkg::*;

	localparam logic [LabelW-1:0] OwnLabel = LabelW'(Idx);

	logic [LabelW-1:0] label_q;
	token_ctl_t        ctl_q;
	logic [LabelW-1:0] from_q;
	logic [LabelW-1:0] to_q;
	logic              hit_a;
	logic              hit_b;
	logic              rewrite;

	// A lookup token picks up this label for whichever endpoint names us.
	assign hit_a   = ctl_in.vld && !ctl_in.relabel && (32'(ctl_in.a) == Idx);
	assign hit_b   = ctl_in.vld && !ctl_in.relabel && (32'(ctl_in.b) == Idx);
	assign rewrite = ctl_in.vld && ctl_in.relabel && (label_q == from_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_q <= OwnLabel;
			ctl_q   <= '0;
		end else begin
			if (clr) begin
				label_q <= OwnLabel;
			end else if (rewrite) begin
				label_q <= to_in;
			end
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		from_q <= hit_b ? label_q : from_in;
		to_q   <= hit_a ? label_q : to_in;
	end

	assign ctl_out  = ctl_q;
	assign from_out = from_q;
	assign to_out   = to_q;

endmodule

`default_nettype wire
